### src/tdpt_pkg.sv
// Trial-division prime test: shared types and constants.
// Used by the controller, the datapath and the top level. No dependencies.
`timescale 1ns / 1ps

package tdpt_pkg;

  localparam int NUMBER_W            = 32;
  localparam int IN_TDATA_W          = 32;
  localparam int OUT_TDATA_W         = 8;
  localparam int DEFAULT_VALUE_WIDTH = 32;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLASSIFY,
    S_DIVIDE,
    S_CHECK,
    S_BOUND,
    S_FINISH
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic advance;
    logic set_verdict;
    logic verdict;
    logic write_out;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic trivial;     // two or three
    logic reject;      // below two or even
    logic last_bit;
    logic rem_zero;
    logic past_bound;  // divisor squared exceeds number
    logic out_free;
  } sts_t;

endpackage

### src/tdpt_datapath.sv
// Trial-division prime test: datapath with the bit-serial remainder unit,
// divisor and square registers, and the output register. Depends on tdpt_pkg.
`timescale 1ns / 1ps

module tdpt_datapath #(
  parameter int VALUE_WIDTH = tdpt_pkg::DEFAULT_VALUE_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [tdpt_pkg::NUMBER_W-1:0] number,
  input  tdpt_pkg::cmd_t                cmd,
  output tdpt_pkg::sts_t                sts,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          is_prime
);

  localparam int CW = $clog2(VALUE_WIDTH);

  logic [VALUE_WIDTH+tdpt_pkg::NUMBER_W-1:0] number_ext;
  logic [VALUE_WIDTH-1:0] n_in;
  logic [VALUE_WIDTH-1:0] n;
  logic [VALUE_WIDTH-1:0] d;
  logic [VALUE_WIDTH+1:0] sq;
  logic [VALUE_WIDTH-1:0] rem;
  logic [CW-1:0]          ctr;
  logic                   verdict;
  logic [VALUE_WIDTH:0]   rem_shift;
  logic [VALUE_WIDTH:0]   rem_sub;
  logic                   rem_ge;
  logic [VALUE_WIDTH-1:0] rem_step;

  assign number_ext = {{VALUE_WIDTH{1'b0}}, number};
  assign n_in       = number_ext[VALUE_WIDTH-1:0];

  // one restoring remainder step per cycle, MSB first
  assign rem_shift = {rem, n[ctr]};
  assign rem_ge    = rem_shift >= {1'b0, d};
  assign rem_sub   = rem_shift - {1'b0, d};
  assign rem_step  = rem_ge ? rem_sub[VALUE_WIDTH-1:0] : rem_shift[VALUE_WIDTH-1:0];

  assign sts.trivial    = (n == VALUE_WIDTH'(2)) || (n == VALUE_WIDTH'(3));
  assign sts.reject     = (n < VALUE_WIDTH'(2)) || !n[0];
  assign sts.last_bit   = (ctr == '0);
  assign sts.rem_zero   = (rem == '0);
  assign sts.past_bound = sq > {2'b00, n};
  assign sts.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n   <= n_in;
      d   <= VALUE_WIDTH'(3);
      sq  <= (VALUE_WIDTH+2)'(9);
      rem <= '0;
      ctr <= CW'(VALUE_WIDTH - 1);
    end else if (cmd.div_step) begin
      rem <= rem_step;
      ctr <= ctr - 1'b1;
    end else if (cmd.advance) begin
      // (d+2)^2 = d^2 + 4d + 4
      d   <= d + VALUE_WIDTH'(2);
      sq  <= sq + {d, 2'b00} + (VALUE_WIDTH+2)'(4);
      rem <= '0;
      ctr <= CW'(VALUE_WIDTH - 1);
    end
    if (cmd.set_verdict) begin
      verdict <= cmd.verdict;
    end
    if (cmd.write_out) begin
      is_prime <= verdict;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.write_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

### src/tdpt_ctrl.sv
// Trial-division prime test: controller state machine sequencing the datapath.
// Depends on tdpt_pkg.
`timescale 1ns / 1ps

module tdpt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  tdpt_pkg::sts_t sts,
  output tdpt_pkg::cmd_t cmd
);

  tdpt_pkg::state_t state;
  tdpt_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tdpt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      tdpt_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = tdpt_pkg::S_CLASSIFY;
        end
      end
      tdpt_pkg::S_CLASSIFY: begin
        priority if (sts.trivial) begin
          cmd.set_verdict = 1'b1;
          cmd.verdict     = 1'b1;
          state_next      = tdpt_pkg::S_FINISH;
        end else if (sts.reject) begin
          cmd.set_verdict = 1'b1;
          state_next      = tdpt_pkg::S_FINISH;
        end else begin
          state_next = tdpt_pkg::S_DIVIDE;
        end
      end
      tdpt_pkg::S_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (sts.last_bit) begin
          state_next = tdpt_pkg::S_CHECK;
        end
      end
      tdpt_pkg::S_CHECK: begin
        if (sts.rem_zero) begin
          cmd.set_verdict = 1'b1;
          state_next      = tdpt_pkg::S_FINISH;
        end else begin
          cmd.advance = 1'b1;
          state_next  = tdpt_pkg::S_BOUND;
        end
      end
      tdpt_pkg::S_BOUND: begin
        if (sts.past_bound) begin
          cmd.set_verdict = 1'b1;
          cmd.verdict     = 1'b1;
          state_next      = tdpt_pkg::S_FINISH;
        end else begin
          state_next = tdpt_pkg::S_DIVIDE;
        end
      end
      tdpt_pkg::S_FINISH: begin
        if (sts.out_free) begin
          cmd.write_out = 1'b1;
          state_next    = tdpt_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = tdpt_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### src/trial_division_prime_test.sv
// Trial-division prime test: top level joining controller and datapath.
// Depends on tdpt_pkg, tdpt_ctrl and tdpt_datapath.
`timescale 1ns / 1ps

// Each request carries one number (the low VALUE_WIDTH bits are used) and
// produces one result bit, 1 when the number is prime. 0..3 and even numbers
// are answered from the classify state, with no division. Odd numbers from 5
// up are tried against the odd divisors 3, 5, 7, ..., 3 always and each later
// one while its square does not exceed the number; each divisor goes through
// the shared remainder unit, one bit per cycle, then a check and a bound state.
// A composite stops at its smallest factor. One request is worked on at a time;
// a finished result is held in an output register, so the next request is
// taken while it waits.

module trial_division_prime_test #(
  parameter int VALUE_WIDTH = tdpt_pkg::DEFAULT_VALUE_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [tdpt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // [31:0] number
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [tdpt_pkg::OUT_TDATA_W-1:0] m_axis_tdata    // [0] is_prime, [7:1] zero
);

  tdpt_pkg::cmd_t cmd;
  tdpt_pkg::sts_t sts;
  logic           is_prime;

  tdpt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tdpt_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .number    (s_axis_tdata[tdpt_pkg::NUMBER_W-1:0]),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .is_prime  (is_prime)
  );

  assign m_axis_tdata = {(tdpt_pkg::OUT_TDATA_W-1)'(0), is_prime};

endmodule

### src/tdpt_checker.sv
// Trial-division prime test: port-level checker and its bind to the top level.
// Depends on trial_division_prime_test.
`timescale 1ns / 1ps

module tdpt_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [31:0] s_axis_tdata,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while busy");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[7:1] == 7'd0)
    else $error("result padding not zero");

  a_two_prime: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tdata == 32'd2 && !m_axis_tvalid
      |-> ##3 (m_axis_tvalid && m_axis_tdata[0]))
    else $error("two not reported prime");

  a_mult4_composite: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tdata[1:0] == 2'b00 && !m_axis_tvalid
      |-> ##3 (m_axis_tvalid && !m_axis_tdata[0]))
    else $error("multiple of four reported prime");

endmodule

bind trial_division_prime_test tdpt_checker u_tdpt_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### sim/tb.sv
// Testbench for trial_division_prime_test: streams numbers in, checks each prime verdict.
// Depends on tdpt_pkg and trial_division_prime_test; the expected verdicts come from a
// trial-division predictor held here.
`timescale 1ns / 1ps

module tb;

  localparam int          VALUE_WIDTH     = tdpt_pkg::DEFAULT_VALUE_WIDTH;
  localparam int          RANDOM_REQUESTS = 70;
  localparam int          STEADY_REQUESTS = 30;
  localparam int          HOLD_CYCLES     = 2000;
  localparam int          DRAIN_CYCLES    = 16;
  localparam int          STALL_LIMIT     = 400000;
  localparam int          REPORT_LIMIT    = 10;
  localparam int unsigned IDLE_PERCENT    = 13;

  typedef struct {
    logic [tdpt_pkg::NUMBER_W-1:0] number;
    logic                          verdict;
  } prime_case_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [tdpt_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [31:0] number
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [tdpt_pkg::OUT_TDATA_W-1:0] m_axis_tdata;        // [0] is_prime, [7:1] zero

  prime_case_t verdict_q[$];
  int          error_count = 0;
  int          stall_cycles = 0;
  int          hold_left = 0;
  int unsigned hold_seq = 0;
  int unsigned hold_seen = 0;
  bit          steady = 1'b0;

  trial_division_prime_test #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic prime_verdict(input logic [tdpt_pkg::NUMBER_W-1:0] raw);
    longint unsigned n;
    longint unsigned d;
    n = 64'(raw);
    if (VALUE_WIDTH < 64) begin
      n = n & ((64'd1 << VALUE_WIDTH) - 64'd1);
    end
    if (n == 2 || n == 3) begin
      return 1'b1;
    end
    if (n < 2 || n[0] == 1'b0) begin
      return 1'b0;
    end
    d = 3;
    do begin
      if (n % d == 0) begin
        return 1'b0;
      end
      d += 2;
    end while (d <= n / d);
    return 1'b1;
  endfunction

  task automatic send_number(input logic [tdpt_pkg::NUMBER_W-1:0] n);
    prime_case_t req;
    while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= n;
    do @(posedge clk); while (!s_axis_tready);
    req.number  = n;
    req.verdict = prime_verdict(n);
    verdict_q.push_back(req);
  endtask

  // receiver: random stalls (none in steady mode), or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  always @(posedge clk) begin
    prime_case_t exp_case;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (verdict_q.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
          $display("ERROR: result 0x%02h with no request pending", m_axis_tdata);
        end
      end else begin
        exp_case = verdict_q.pop_front();
        if (m_axis_tdata !== {{(tdpt_pkg::OUT_TDATA_W-1){1'b0}}, exp_case.verdict}) begin
          error_count++;
          if (error_count <= REPORT_LIMIT) begin
            $display("ERROR: number %0d: expected is_prime %0b, got tdata 0x%02h",
                     exp_case.number, exp_case.verdict, m_axis_tdata);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL trial_division_prime_test");
      $finish;
    end
  end

  task automatic test_small_values;
    logic [tdpt_pkg::NUMBER_W-1:0] vals[10] = '{0, 1, 2, 3, 4, 5, 7, 9, 25, 49};
    foreach (vals[i]) send_number(vals[i]);
  endtask

  task automatic test_extremes;
    logic [tdpt_pkg::NUMBER_W-1:0] vals[6] = '{32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000,
                                               32'h8000_0001, 32'h5555_5555, 32'hAAAA_AAAB};
    foreach (vals[i]) send_number(vals[i]);
  endtask

  // divisor squared landing exactly on the number, and primes needing long searches
  task automatic test_square_bound;
    logic [tdpt_pkg::NUMBER_W-1:0] vals[5] = '{121, 1042441, 16752649, 1021, 16777213};
    foreach (vals[i]) send_number(vals[i]);
  endtask

  // start from an idle block so the hold-off fills the output and stalls the input
  task automatic test_backpressure;
    s_axis_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    hold_seq++;
    steady = 1'b1;
    repeat (8) send_number($urandom_range(0, 2000));
    steady = 1'b0;
  endtask

  task automatic test_random_mix;
    logic [tdpt_pkg::NUMBER_W-1:0] n;
    int unsigned                   d;
    int unsigned                   kind;
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      steady = (i < STEADY_REQUESTS);
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        n = $urandom_range(0, 32'h0000_FFFF);
      end else if (kind < 70) begin
        n = $urandom_range(0, 32'h000F_FFFF);
      end else if (kind < 80) begin
        n = $urandom & ~32'd1;
      end else begin
        // wide composite with a small odd factor keeps the search short
        d = 2 * $urandom_range(1, 127) + 1;
        n = d * $urandom_range(d, 32'hFFFF_FFFF / d);
      end
      send_number(n);
    end
    steady = 1'b0;
  endtask

  task automatic wait_drained;
    s_axis_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_small_values();
    test_extremes();
    test_square_bound();
    test_backpressure();
    test_random_mix();
    wait_drained();
    if (error_count == 0) begin
      $display("PASS trial_division_prime_test");
    end else begin
      $display("FAIL trial_division_prime_test");
    end
    $finish;
  end

endmodule
